// ----- rtl/plid_pkg.sv -----
package plid_pkg;

  localparam int MODE_W   = 2;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic ins;
    logic del;
  } cell_op_t;

endpackage

// ----- rtl/plid_cell.sv -----
module plid_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  plid_pkg::cell_op_t                op,
  input  logic [IW-1:0]                     k,
  input  logic signed [plid_pkg::DATA_W-1:0] value,
  input  logic signed [plid_pkg::DATA_W-1:0] left,
  input  logic signed [plid_pkg::DATA_W-1:0] right,
  output logic signed [plid_pkg::DATA_W-1:0] data,
  output logic signed [plid_pkg::DATA_W-1:0] hit
);
  import plid_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  // insert: cells past k take the left neighbor, cell k takes the new word
  // delete: cells from k on take the right neighbor
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (MY_IDX > k) begin
        data <= left;
      end else if (MY_IDX == k) begin
        data <= value;
      end
    end else if (op.del && MY_IDX >= k) begin
      data <= right;
    end
  end

  assign hit = (MY_IDX == k) ? data : '0;

endmodule

// ----- rtl/positional_list_insert_delete.sv -----
// Result strobed on done in the cycle after start is taken.
// Throughput: one command per cycle; busy stays low, insert and delete shift
// the whole row of cells in parallel.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
// Results cannot be stalled: each is on rsp while done is high and stays until the next command is taken.
module positional_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  plid_pkg::cmd_t cmd,
  output logic           done,
  output plid_pkg::rsp_t rsp
);
  import plid_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CW-1:0]   cnt, cnt_next;
  logic [CMPW-1:0] pos_w, cnt_w;
  logic            accept, full, ins_pos_ok, sel_pos_ok;
  logic [IW-1:0]   k;
  cell_op_t        op;
  logic [STATUS_W-1:0]      status_next;
  logic signed [DATA_W-1:0] data_next, sel_data;

  logic signed [DATA_W-1:0] cell_q   [CAPACITY];
  logic signed [DATA_W-1:0] cell_hit [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign pos_w      = CMPW'(cmd.position);
  assign cnt_w      = CMPW'(cnt);
  assign full       = (cnt == CW'(CAPACITY));
  assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + CMPW'(1));
  assign sel_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign k          = IW'(pos_w - CMPW'(1));

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data = sel_data | cell_hit[i];
    end
  end

  always_comb begin
    op          = '0;
    status_next = ST_INVALID;
    data_next   = '0;
    cnt_next    = cnt;
    case (cmd.mode)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (ins_pos_ok) begin
          status_next = ST_OK;
          op.ins      = accept;
          cnt_next    = cnt + CW'(1);
        end
      end
      MODE_DELETE: begin
        if (sel_pos_ok) begin
          status_next = ST_OK;
          data_next   = sel_data;
          op.del      = accept;
          cnt_next    = cnt - CW'(1);
        end
      end
      MODE_READ: begin
        if (sel_pos_ok) begin
          status_next = ST_OK;
          data_next   = sel_data;
        end
      end
      default: begin
        status_next = ST_INVALID;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end

    plid_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .op    (op),
      .k     (k),
      .value (cmd.value),
      .left  (left_d),
      .right (right_d),
      .data  (cell_q[i]),
      .hit   (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status   <= status_next;
      rsp.data_out <= data_next;
      rsp.count    <= COUNT_W'(cnt_next);
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import plid_pkg::*;

  localparam int CAPACITY = 16;
  localparam int N_RANDOM = 630;

  typedef struct {
    cmd_t cmd;
    int   idle_pct;
    bit   drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  stim_t pending_cmds[$];
  rsp_t  expected_rsps[$];

  // shadow of the list, advanced at each accepted transfer
  logic [DATA_W-1:0] list_words [CAPACITY];
  int unsigned list_len = 0;

  // list length as the stimulus generator sees it, running ahead of the driver
  int unsigned gen_len = 0;

  int accepted_cnt = 0;
  int results_cnt = 0;
  int fail_cnt = 0;
  int n_full = 0;
  int n_invalid = 0;
  int peak_len = 0;

  positional_list_insert_delete #(.CAPACITY(CAPACITY)) i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic rsp_t list_apply(cmd_t c);
    rsp_t r;
    int unsigned p;
    int unsigned i;
    r.status = ST_INVALID;
    r.data_out = '0;
    p = c.position;
    case (c.mode)
      MODE_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p >= 1 && p <= list_len + 1) begin
          for (i = list_len; i > p - 1; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = c.value;
          list_len++;
          r.status = ST_OK;
        end
      end
      MODE_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          r.data_out = list_words[p-1];
          for (i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          r.status = ST_OK;
        end
      end
      MODE_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.data_out = list_words[p-1];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  function automatic void queue_cmd(logic [MODE_W-1:0] m, int unsigned p,
                                    logic [DATA_W-1:0] v, int idle, bit drain);
    stim_t s;
    s.cmd.mode = m;
    s.cmd.position = POS_W'(p);
    s.cmd.value = v;
    s.idle_pct = idle;
    s.drain = drain;
    pending_cmds.push_back(s);
    if (m == MODE_INSERT && gen_len < CAPACITY && p >= 1 && p <= gen_len + 1)
      gen_len++;
    else if (m == MODE_DELETE && p >= 1 && p <= gen_len)
      gen_len--;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // valid position most of the time, otherwise anything the field can hold
  function automatic int unsigned pick_pos(int unsigned span);
    if (span > 0 && $urandom_range(0, 99) < 85) return $urandom_range(1, span);
    return $urandom_range(0, 31);
  endfunction

  // driver
  always @(posedge clk) begin
    logic take;
    logic start_v;
    cmd_t cmd_v;
    take = start && !busy;
    start_v = start;
    cmd_v = cmd;
    if (rst) begin
      start_v = 1'b0;
    end else begin
      if (take) begin
        expected_rsps.push_back(list_apply(cmd));
        void'(pending_cmds.pop_front());
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!start || take) begin
        start_v = 1'b0;
        if (pending_cmds.size() != 0) begin
          if (pending_cmds[0].drain && (accepted_cnt + take != results_cnt)) begin
            start_v = 1'b0;
          end else if ($urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
            start_v = 1'b1;
            cmd_v = pending_cmds[0].cmd;
          end
        end
      end
    end
    start <= start_v;
    cmd <= cmd_v;
  end

  // monitor
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && done) begin
      results_cnt <= results_cnt + 1;
      if (expected_rsps.size() == 0) begin
        $error("result with no transfer outstanding: status %0d data %0d count %0d",
               rsp.status, rsp.data_out, rsp.count);
        fail_cnt++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp.status);
          fail_cnt++;
        end
        if (rsp.data_out !== exp_r.data_out) begin
          $error("data_out: expected %0d, got %0d", exp_r.data_out, rsp.data_out);
          fail_cnt++;
        end
        if (rsp.count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, rsp.count);
          fail_cnt++;
        end
        if (exp_r.status == ST_FULL) n_full++;
        if (exp_r.status == ST_INVALID) n_invalid++;
        if (exp_r.count > peak_len) peak_len = exp_r.count;
      end
    end
  end

  initial begin
    int phase_idle[4];
    int insert_bias;
    int unsigned m;
    phase_idle = '{0, 51, 33, 0};

    // directed: empty list, head/middle/tail, bad positions, unused mode
    queue_cmd(MODE_READ,   1, 32'h1234_5678, 0, 0);
    queue_cmd(MODE_DELETE, 1, 32'h0, 0, 0);
    queue_cmd(MODE_INSERT, 0, 32'h5555_5555, 0, 0);
    queue_cmd(MODE_INSERT, 2, 32'haaaa_aaaa, 0, 0);
    queue_cmd(MODE_INSERT, 1, 32'h8000_0000, 0, 0);
    queue_cmd(MODE_INSERT, 2, 32'h7fff_ffff, 0, 0);
    queue_cmd(MODE_INSERT, 1, 32'hffff_ffff, 0, 0);
    queue_cmd(MODE_INSERT, 2, 32'h0000_0000, 0, 0);
    queue_cmd(MODE_READ,   1, 32'h0, 0, 0);
    queue_cmd(MODE_READ,   4, 32'h0, 0, 0);
    queue_cmd(MODE_READ,   5, 32'h0, 0, 0);
    queue_cmd(MODE_READ,   0, 32'h0, 0, 0);
    queue_cmd(2'd3,        1, 32'hffff_ffff, 0, 0);
    queue_cmd(MODE_INSERT, 31, 32'h0f0f_0f0f, 0, 0);
    queue_cmd(MODE_DELETE, 5, 32'h0, 0, 0);
    queue_cmd(MODE_DELETE, 1, 32'h0, 0, 0);
    queue_cmd(MODE_DELETE, 3, 32'h0, 0, 0);
    queue_cmd(MODE_DELETE, 1, 32'h0, 0, 0);
    queue_cmd(MODE_DELETE, 1, 32'h0, 0, 0);
    queue_cmd(MODE_READ,   31, 32'h0, 0, 0);
    queue_cmd(MODE_DELETE, 0, 32'h0, 0, 0);
    queue_cmd(2'd3,        31, 32'h7fff_ffff, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      // fill to capacity and push on past it, then wander
      while (gen_len < CAPACITY)
        queue_cmd(MODE_INSERT, pick_pos(gen_len + 1), pick_value(), phase_idle[ph],
                  (ph == 1 && gen_len == 0) ? 1'b1 : 1'b0);
      queue_cmd(MODE_INSERT, $urandom_range(0, 31), pick_value(), phase_idle[ph], 0);
      queue_cmd(MODE_INSERT, CAPACITY + 1, pick_value(), phase_idle[ph], 0);
      insert_bias = 30;
      for (int k = 0; k < N_RANDOM / 4 - 18; k++) begin
        if (k % 40 == 0) insert_bias = (insert_bias == 30) ? 70 : 30;
        m = $urandom_range(0, 99);
        if (m < 3)
          queue_cmd(2'd3, $urandom_range(0, 31), $urandom, phase_idle[ph], 0);
        else if (m < 15)
          queue_cmd(MODE_READ, pick_pos(gen_len), $urandom, phase_idle[ph], 0);
        else if ($urandom_range(0, 99) < insert_bias)
          queue_cmd(MODE_INSERT, pick_pos(gen_len + 1), pick_value(), phase_idle[ph], 0);
        else
          queue_cmd(MODE_DELETE, pick_pos(gen_len), $urandom, phase_idle[ph], 0);
      end
      // drain the list so that deleting the last entry comes up every phase
      while (gen_len > 0)
        queue_cmd(MODE_DELETE, pick_pos(gen_len), $urandom, phase_idle[ph], 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start || accepted_cnt != results_cnt)
      @(negedge clk);
    repeat (4) @(negedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d results never arrived", expected_rsps.size());
      fail_cnt++;
    end

    $display("%0d transfers, %0d results: %0d full, %0d invalid, peak length %0d",
             accepted_cnt, results_cnt, n_full, n_invalid, peak_len);
    $display("idle mixes of 0, 51 and 33 percent, with one full drain before a transfer");
    if (fail_cnt == 0) begin
      $display("PASS positional_list_insert_delete");
    end else begin
      $display("FAIL positional_list_insert_delete");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL positional_list_insert_delete");
    $finish;
  end

endmodule
